// ===== rtl/core/kmqf_pkg.sv =====
// kmqf_pkg: shared types and constants of the quick-find spanning tree block
// used by kmqf_engine, kmqf_out_reg and kruskal_mst_quick_find_top
`default_nettype none

package kmqf_pkg;

  // fixed field widths
  localparam int VTX_W  = 10;
  localparam int WGT_W  = 16;
  localparam int CNT_W  = 11;
  localparam int EDGE_W = 10;
  localparam int COST_W = 32;

  localparam logic [CNT_W-1:0]  CNT_RESET = 11'd1024;
  localparam logic [COST_W-1:0] COST_MAX  = 32'hFFFF_FFFF;
  localparam logic [EDGE_W-1:0] EDGES_MAX = 10'd1023;

  // engine sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_U,
    ST_RD_V,
    ST_CMP,
    ST_SCAN,
    ST_RESULT
  } kmqf_state_e;

  // one result item from engine to output stage
  typedef struct packed {
    logic              accepted;
    logic              bad;
    logic [EDGE_W-1:0] edges;
    logic [COST_W-1:0] cost;
    logic              done;
  } kmqf_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/kmqf_ram.sv =====
// kmqf_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module kmqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kmqf_engine.sv =====
// kmqf_engine: label memory sequencer: clear pass, label lookups, relabel scan,
// saturating totals; depends on kmqf_pkg and kmqf_ram
`default_nettype none

module kmqf_engine #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [kmqf_pkg::CNT_W-1:0]    cfg_data_i,
  // edge input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [kmqf_pkg::VTX_W-1:0]    u_i,
  input  wire logic [kmqf_pkg::VTX_W-1:0]    v_i,
  input  wire logic [kmqf_pkg::WGT_W-1:0]    w_i,
  input  wire logic                          last_i,
  // result
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output kmqf_pkg::kmqf_result_t             res_o
);

  localparam int ADDR_W = $clog2(MAX_VERTICES);
  localparam int IW     = ADDR_W + 1;
  localparam int XW     = ADDR_W + kmqf_pkg::VTX_W;
  localparam logic [IW-1:0] DEPTH_IDX = IW'(MAX_VERTICES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_VERTICES - 1);

  kmqf_pkg::kmqf_state_e state_q, state_d;

  logic [kmqf_pkg::CNT_W-1:0]  cfg_q;
  logic [IW-1:0]               idx_q;
  logic [kmqf_pkg::VTX_W-1:0]  u_q, v_q;
  logic [kmqf_pkg::WGT_W-1:0]  w_q;
  logic                        last_q;
  logic                        acc_q, bad_q;
  logic [ADDR_W-1:0]           old_lab_q, new_lab_q;
  logic [kmqf_pkg::COST_W-1:0] cost_q;
  logic [kmqf_pkg::EDGE_W-1:0] edges_q;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, ram_wdata, ram_rdata;
  logic [XW-1:0]     u_ext, v_ext;
  logic [IW-1:0]     idx_m1;
  logic              in_xfer, res_xfer, bad_in, lab_diff, lab_match;
  logic [kmqf_pkg::COST_W:0] cost_sum;

  kmqf_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_VERTICES)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign u_ext     = XW'(u_q);
  assign v_ext     = XW'(v_q);
  assign idx_m1    = idx_q - IW'(1);
  assign in_xfer   = in_valid_i && in_ready_o;
  assign res_xfer  = res_valid_o && res_ready_i;
  assign lab_diff  = ram_rdata != old_lab_q;
  assign lab_match = ram_rdata == old_lab_q;
  assign cost_sum  = {1'b0, cost_q} + (kmqf_pkg::COST_W + 1)'(w_q);

  // endpoint range check against the count in effect
  assign bad_in = (32'(u_i) >= 32'(cfg_q)) || (32'(v_i) >= 32'(cfg_q)) ||
                  (32'(u_i) >= 32'(MAX_VERTICES)) || (32'(v_i) >= 32'(MAX_VERTICES));

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmqf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and memory port control
  always_comb begin
    state_d     = state_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[ADDR_W-1:0];
    ram_wdata   = idx_q[ADDR_W-1:0];
    ram_re      = 1'b0;
    ram_raddr   = u_ext[ADDR_W-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      kmqf_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = kmqf_pkg::ST_IDLE;
        end
      end
      kmqf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = bad_in ? kmqf_pkg::ST_RESULT : kmqf_pkg::ST_RD_U;
        end
      end
      kmqf_pkg::ST_RD_U: begin
        ram_re    = 1'b1;
        ram_raddr = u_ext[ADDR_W-1:0];
        state_d   = kmqf_pkg::ST_RD_V;
      end
      kmqf_pkg::ST_RD_V: begin
        ram_re    = 1'b1;
        ram_raddr = v_ext[ADDR_W-1:0];
        state_d   = kmqf_pkg::ST_CMP;
      end
      kmqf_pkg::ST_CMP: begin
        state_d = lab_diff ? kmqf_pkg::ST_SCAN : kmqf_pkg::ST_RESULT;
      end
      kmqf_pkg::ST_SCAN: begin
        // read entry idx while writing back entry idx-1
        if (idx_q != DEPTH_IDX) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
        end else begin
          state_d = kmqf_pkg::ST_RESULT;
        end
        if (idx_q != '0 && lab_match) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[ADDR_W-1:0];
          ram_wdata = new_lab_q;
        end
      end
      kmqf_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = last_q ? kmqf_pkg::ST_CLEAR : kmqf_pkg::ST_IDLE;
        end
      end
      default: state_d = kmqf_pkg::ST_CLEAR;
    endcase
  end

  // sweep counter for clear pass and relabel scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (state_q == kmqf_pkg::ST_CLEAR) begin
      idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IW'(1);
    end else if (state_q == kmqf_pkg::ST_SCAN) begin
      idx_q <= idx_q + IW'(1);
    end else begin
      idx_q <= '0;
    end
  end

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= kmqf_pkg::CNT_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // edge capture and label capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      u_q    <= u_i;
      v_q    <= v_i;
      w_q    <= w_i;
      last_q <= last_i;
      bad_q  <= bad_in;
      acc_q  <= 1'b0;
    end
    if (state_q == kmqf_pkg::ST_RD_V) begin
      old_lab_q <= ram_rdata;
    end
    if (state_q == kmqf_pkg::ST_CMP) begin
      new_lab_q <= ram_rdata;
      acc_q     <= lab_diff;
    end
  end

  // saturating totals, cleared at reset and at graph end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q  <= '0;
      edges_q <= '0;
    end else if (res_xfer && last_q) begin
      cost_q  <= '0;
      edges_q <= '0;
    end else if (state_q == kmqf_pkg::ST_CMP && lab_diff) begin
      cost_q <= cost_sum[kmqf_pkg::COST_W] ? kmqf_pkg::COST_MAX
                                           : cost_sum[kmqf_pkg::COST_W-1:0];
      if (edges_q != kmqf_pkg::EDGES_MAX) begin
        edges_q <= edges_q + kmqf_pkg::EDGE_W'(1);
      end
    end
  end

  // result item
  always_comb begin
    res_o.accepted = acc_q;
    res_o.bad      = bad_q;
    res_o.edges    = edges_q;
    res_o.cost     = cost_q;
    res_o.done     = last_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kmqf_out_reg.sv =====
// kmqf_out_reg: output register between engine and the master stream side
// depends on kmqf_pkg
`default_nettype none

module kmqf_out_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   res_valid_i,
  output logic                        res_ready_o,
  input  wire kmqf_pkg::kmqf_result_t res_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output kmqf_pkg::kmqf_result_t      out_o
);

  logic                   full_q;
  kmqf_pkg::kmqf_result_t data_q;

  assign res_ready_o = !full_q || out_ready_i;
  assign out_valid_o = full_q;
  assign out_o       = data_q;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (res_ready_o) begin
      full_q <= res_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kruskal_mst_quick_find_top.sv =====
// kruskal_mst_quick_find_top: minimum spanning tree builder, quick-find labels
// depends on kmqf_pkg, kmqf_engine (with kmqf_ram) and kmqf_out_reg
//
//  channel  | dir | signals                              | content
//  ---------+-----+--------------------------------------+------------------------------
//  s_axis   | in  | tvalid tready tdata[39:0] tlast      | one edge, tlast = last edge
//  m_axis   | out | tvalid tready tdata[47:0] tuser tlast| totals, flags, tlast = done
//  cfg      | in  | cfg_valid_i cfg_ready_o cfg_data_i   | vertex_count, always ready
//
// A bad-vertex edge goes from idle straight to its result, a rejected edge first
// through the two label reads and the compare, an accepted edge also through the
// relabel scan, which reads one label per cycle through the single read port of
// the label ram. After the last edge of a graph, and after reset, a clearing pass
// rewrites every label; no edge transfer is taken then. A stalled result sits in
// the output register while the next edge is taken.
`default_nettype none

module kruskal_mst_quick_find_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_data_i,    // vertex_count
  // edge stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // first_vertex[9:0], second_vertex[19:10],
                                          // edge_weight[35:20], zero pad[39:36]
  input  wire logic        s_axis_tlast,  // last_edge
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // tree_edges[9:0], tree_cost[41:10],
                                          // zero pad[47:42]
  output logic [1:0]       m_axis_tuser,  // edge_accepted[0], bad_vertex[1]
  output logic             m_axis_tlast   // graph_done
);

  logic                   res_valid, res_ready;
  kmqf_pkg::kmqf_result_t res, out;

  assign cfg_ready_o = 1'b1;

  kmqf_engine #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .u_i         (s_axis_tdata[9:0]),
    .v_i         (s_axis_tdata[19:10]),
    .w_i         (s_axis_tdata[35:20]),
    .last_i      (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  kmqf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  // pack result fields
  assign m_axis_tdata = {6'd0, out.cost, out.edges};
  assign m_axis_tuser = {out.bad, out.accepted};
  assign m_axis_tlast = out.done;

  // after an edge transfer the engine is busy and tready drops
  a_busy_after_edge : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready
  ) else $error("edge taken in the cycle after an edge transfer");

  // a bad-vertex edge never enters the tree
  a_bad_not_accepted : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |-> !(res.bad && res.accepted)
  ) else $error("result flagged both bad vertex and accepted");

  // end of graph starts the clearing pass, which blocks edges
  a_clear_after_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && res.done |=> !s_axis_tready ##1 !s_axis_tready
  ) else $error("edge accepted during label clearing pass");

endmodule

`default_nettype wire
